// File: rtl/lru_key_value_cache_macros.svh
// ----------------------------------------------------------------------------
// lru_key_value_cache_macros.svh
// assertion macros used by the lru key-value cache top level
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define LKV_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("lru cache: property failed");

// condition must never be seen outside reset
`define LKV_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
	else $error("lru cache: forbidden condition seen");

`else

`define LKV_ASSERT(lbl, clk, rstn, prop)
`define LKV_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// types, codes and default sizes of the lru key-value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

	// default sizes handed to the top level parameters
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	// fixed field widths
	localparam int REQ_W = 2;
	localparam int CAP_W = 5;
	localparam int OCC_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request kinds
	typedef enum logic [REQ_W-1:0] {
		REQ_PUT    = 2'd0,
		REQ_GET    = 2'd1,
		REQ_REMOVE = 2'd2
	} req_kind_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLAN,
		ST_UPDATE,
		ST_DONE
	} state_t;

	// write strobes from the sequencer to the entry store
	typedef struct packed {
		logic key_we;
		logic val_we;
		logic rank_we;
	} store_wr_t;

endpackage

// File: rtl/lkv_store.sv
// ----------------------------------------------------------------------------
// lkv_store
// key, value and recency rank memories, one read and one write port each
// ----------------------------------------------------------------------------
module lkv_store #(
	parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic [$clog2(ENTRIES)-1:0]  rd_addr,
	input  lkv_pkg::store_wr_t          wr,
	input  logic [$clog2(ENTRIES)-1:0]  kv_addr,
	input  logic [KEY_BITS-1:0]         key_wdata,
	input  logic [VALUE_BITS-1:0]       val_wdata,
	input  logic [$clog2(ENTRIES)-1:0]  rank_addr,
	input  logic [$clog2(ENTRIES)-1:0]  rank_wdata,
	output logic [KEY_BITS-1:0]         key_rdata,
	output logic [VALUE_BITS-1:0]       val_rdata,
	output logic [$clog2(ENTRIES)-1:0]  rank_rdata
);
	import lkv_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
	logic [IDX_W-1:0]      rank_mem [ENTRIES];

	// key memory
	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[kv_addr] <= key_wdata;
		end
		key_rdata <= key_mem[rd_addr];
	end

	// value memory
	always_ff @(posedge clk) begin
		if (wr.val_we) begin
			val_mem[kv_addr] <= val_wdata;
		end
		val_rdata <= val_mem[rd_addr];
	end

	// rank memory, written one entry behind the read sweep
	always_ff @(posedge clk) begin
		if (wr.rank_we) begin
			rank_mem[rank_addr] <= rank_wdata;
		end
		rank_rdata <= rank_mem[rd_addr];
	end

endmodule

// File: rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// sequencer with the shared per-entry unit: a scan sweep for match, lru and
// free slot, then an update sweep that rewrites ranks and valid bits and
// writes the key and value where the plan asks for it
module lkv_ctrl #(
	parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          req_valid,
	input  logic [lkv_pkg::REQ_W-1:0]     req_type,
	input  logic [KEY_BITS-1:0]           key,
	input  logic [VALUE_BITS-1:0]         value_in,
	output logic                          busy,
	// configuration
	input  logic [lkv_pkg::CAP_W-1:0]     cap,
	// result side
	input  logic                          out_free,
	output logic                          res_vld,
	output logic                          res_status,
	output logic [VALUE_BITS-1:0]         res_value,
	output logic [$clog2(ENTRIES+1)-1:0]  count,
	// entry store
	output logic [$clog2(ENTRIES)-1:0]    rd_addr,
	output lkv_pkg::store_wr_t            wr,
	output logic [$clog2(ENTRIES)-1:0]    kv_addr,
	output logic [KEY_BITS-1:0]           key_wdata,
	output logic [VALUE_BITS-1:0]         val_wdata,
	output logic [$clog2(ENTRIES)-1:0]    rank_addr,
	output logic [$clog2(ENTRIES)-1:0]    rank_wdata,
	input  logic [KEY_BITS-1:0]           key_rdata,
	input  logic [VALUE_BITS-1:0]         val_rdata,
	input  logic [$clog2(ENTRIES)-1:0]    rank_rdata
);
	import lkv_pkg::*;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	state_t state_q, state_d;

	logic [CNT_W-1:0]   cnt_q;
	logic               sweep_last;
	logic               issue;
	logic               pipe_vld_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;

	// request held for the whole sequence
	logic [REQ_W-1:0]      req_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	// scan results
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [RANK_W-1:0]     hit_rank_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic                  lru_found_q;
	logic [IDX_W-1:0]      lru_idx_q;
	logic [RANK_W-1:0]     lru_rank_q;
	logic                  free_found_q;
	logic [IDX_W-1:0]      free_idx_q;

	// plan, combinational and registered
	logic                  fr_en_d, fr_en_q;
	logic [IDX_W-1:0]      fr_idx_d, fr_idx_q;
	logic [RANK_W-1:0]     fr_rank_d, fr_rank_q;
	logic                  pr_en_d, pr_en_q;
	logic [IDX_W-1:0]      pr_idx_d, pr_idx_q;
	logic [CNT_W-1:0]      pr_lim_d, pr_lim_q;
	logic                  key_we_d, key_we_q;
	logic                  val_we_d, val_we_q;
	logic [IDX_W-1:0]      kv_idx_d, kv_idx_q;
	logic                  status_d, status_q;
	logic [VALUE_BITS-1:0] vout_d, vout_q;
	logic [CNT_W-1:0]      count_new_d, count_new_q;

	logic [CNT_W-1:0]      eff_cap;
	logic                  evict;
	logic                  ins_ok;
	logic [IDX_W-1:0]      new_idx;
	logic [CNT_W-1:0]      cnt_after_evict;

	// shared per-entry unit signals
	logic                  ent_valid;
	logic                  scan_match;
	logic                  scan_lru;
	logic                  ent_v1, ent_v2;
	logic [RANK_W-1:0]     ent_r1, ent_r2;

	// sweep counter runs one past the last entry to drain the read latency
	assign sweep_last = (cnt_q == CNT_W'(ENTRIES));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (req_valid) state_d = ST_SCAN;
			ST_SCAN:   if (sweep_last) state_d = ST_PLAN;
			ST_PLAN:   state_d = ST_UPDATE;
			ST_UPDATE: if (sweep_last) state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy       = (state_q != ST_IDLE);
		res_vld    = (state_q == ST_DONE) && out_free;
		issue      = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && !sweep_last;
		wr.key_we  = (state_q == ST_UPDATE) && (cnt_q == '0) && key_we_q;
		wr.val_we  = (state_q == ST_UPDATE) && (cnt_q == '0) && val_we_q;
		wr.rank_we = (state_q == ST_UPDATE) && pipe_vld_s1;
	end

	assign rd_addr    = cnt_q[IDX_W-1:0];
	assign kv_addr    = kv_idx_q;
	assign key_wdata  = key_q;
	assign val_wdata  = value_q;
	assign rank_addr  = idx_s1;
	assign rank_wdata = ent_r2;
	assign res_status = status_q;
	assign res_value  = vout_q;
	assign count      = count_q;

	// state, sweep counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pipe_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			pipe_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if ((state_q == ST_IDLE) || (state_q == ST_PLAN)) begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
	end

	// shared per-entry unit: scan evaluation
	always_comb begin
		ent_valid  = valid_q[idx_s1];
		scan_match = ent_valid && (key_rdata == key_q);
		scan_lru   = ent_valid && ((CNT_W'(rank_rdata) + CNT_W'(1)) == count_q);
	end

	// shared per-entry unit: rank update, free step then promote step
	always_comb begin
		ent_v1 = ent_valid;
		ent_r1 = rank_rdata;
		if (fr_en_q && (idx_s1 == fr_idx_q)) begin
			ent_v1 = 1'b0;
			ent_r1 = '0;
		end else if (fr_en_q && ent_valid && (rank_rdata > fr_rank_q)) begin
			ent_r1 = rank_rdata - RANK_W'(1);
		end
		ent_v2 = ent_v1;
		ent_r2 = ent_r1;
		if (pr_en_q && (idx_s1 == pr_idx_q)) begin
			ent_v2 = 1'b1;
			ent_r2 = '0;
		end else if (pr_en_q && ent_v1 && (CNT_W'(ent_r1) < pr_lim_q)) begin
			ent_r2 = ent_r1 + RANK_W'(1);
		end
	end

	// request capture and scan results
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req_valid) begin
			req_q        <= req_type;
			key_q        <= key;
			value_q      <= value_in;
			hit_q        <= 1'b0;
			lru_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && pipe_vld_s1) begin
			if (scan_match && !hit_q) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= idx_s1;
				hit_rank_q <= rank_rdata;
				hit_val_q  <= val_rdata;
			end
			if (scan_lru && !lru_found_q) begin
				lru_found_q <= 1'b1;
				lru_idx_q   <= idx_s1;
				lru_rank_q  <= rank_rdata;
			end
			if (!ent_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
		end
	end

	// capacity clamp and insert slot choice
	always_comb begin
		if (cap == '0) begin
			eff_cap = CNT_W'(1);
		end else if (int'(cap) > ENTRIES) begin
			eff_cap = CNT_W'(ENTRIES);
		end else begin
			eff_cap = CNT_W'(cap);
		end
		evict           = (count_q >= eff_cap) && lru_found_q;
		ins_ok          = evict || free_found_q;
		cnt_after_evict = count_q - CNT_W'(evict);
		if (evict && (!free_found_q || (lru_idx_q < free_idx_q))) begin
			new_idx = lru_idx_q;
		end else begin
			new_idx = free_idx_q;
		end
	end

	// plan decoder
	always_comb begin
		fr_en_d     = 1'b0;
		fr_idx_d    = hit_idx_q;
		fr_rank_d   = hit_rank_q;
		pr_en_d     = 1'b0;
		pr_idx_d    = hit_idx_q;
		pr_lim_d    = CNT_W'(hit_rank_q);
		key_we_d    = 1'b0;
		val_we_d    = 1'b0;
		kv_idx_d    = hit_idx_q;
		status_d    = 1'b0;
		vout_d      = '0;
		count_new_d = count_q;
		unique case (req_q)
			REQ_PUT: begin
				status_d = 1'b1;
				if (hit_q) begin
					pr_en_d  = 1'b1;
					val_we_d = 1'b1;
				end else begin
					fr_en_d     = evict;
					fr_idx_d    = lru_idx_q;
					fr_rank_d   = lru_rank_q;
					pr_en_d     = ins_ok;
					pr_idx_d    = new_idx;
					pr_lim_d    = cnt_after_evict;
					key_we_d    = ins_ok;
					val_we_d    = ins_ok;
					kv_idx_d    = new_idx;
					count_new_d = cnt_after_evict + CNT_W'(ins_ok);
				end
			end
			REQ_GET: begin
				if (hit_q) begin
					status_d = 1'b1;
					vout_d   = hit_val_q;
					pr_en_d  = 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (hit_q) begin
					status_d = 1'b1;
					fr_en_d  = 1'b1;
					if (count_q != '0) begin
						count_new_d = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
				status_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PLAN) begin
			fr_en_q     <= fr_en_d;
			fr_idx_q    <= fr_idx_d;
			fr_rank_q   <= fr_rank_d;
			pr_en_q     <= pr_en_d;
			pr_idx_q    <= pr_idx_d;
			pr_lim_q    <= pr_lim_d;
			key_we_q    <= key_we_d;
			val_we_q    <= val_we_d;
			kv_idx_q    <= kv_idx_d;
			status_q    <= status_d;
			vout_q      <= vout_d;
			count_new_q <= count_new_d;
		end
	end

	// valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			if (pipe_vld_s1) begin
				valid_q[idx_s1] <= ent_v2;
			end
			if (sweep_last) begin
				count_q <= count_new_q;
			end
		end
	end

endmodule

// File: rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value store with least-recently-used replacement
//
//  channel   signals                          direction   transfer when
//  req       req_valid req_stall req_type     in          valid && !stall
//            key value_in
//  rsp       rsp_valid rsp_stall status       out         valid && !stall
//            value_out occupancy
//  cfg       cfg_valid cfg_ready cfg_data     in          valid && ready
//
// one request runs from transfer to result as a scan sweep and an update
// sweep over the entry memories, one entry a cycle through the single
// per-entry unit, each sweep running one step past the last entry for the
// registered memory read. req_stall is high for the whole sequence. a result
// waits in the output register while rsp_stall is high; the next request is
// taken meanwhile and held at its end until the register frees. reset clears
// all valid bits at once and sets capacity to 16.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
	parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_data,
	// requests
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [lkv_pkg::REQ_W-1:0] req_type,
	input  logic [KEY_BITS-1:0]       key,
	input  logic [VALUE_BITS-1:0]     value_in,
	// results
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic                      status,
	output logic [VALUE_BITS-1:0]     value_out,
	output logic [lkv_pkg::OCC_W-1:0] occupancy
);
	import lkv_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic [CAP_W-1:0]      cap_q;
	logic                  busy;
	logic                  out_free;
	logic                  res_vld;
	logic                  res_status;
	logic [VALUE_BITS-1:0] res_value;
	logic [CNT_W-1:0]      count_w;
	logic                  rsp_valid_q;
	logic                  rsp_status_q;
	logic [VALUE_BITS-1:0] rsp_value_q;
	logic [OCC_W-1:0]      rsp_occ_q;

	logic [IDX_W-1:0]      rd_addr;
	store_wr_t             wr;
	logic [IDX_W-1:0]      kv_addr;
	logic [KEY_BITS-1:0]   key_wdata;
	logic [VALUE_BITS-1:0] val_wdata;
	logic [IDX_W-1:0]      rank_addr;
	logic [IDX_W-1:0]      rank_wdata;
	logic [KEY_BITS-1:0]   key_rdata;
	logic [VALUE_BITS-1:0] val_rdata;
	logic [IDX_W-1:0]      rank_rdata;

	// capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// sequencer and per-entry unit
	lkv_ctrl #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_type   (req_type),
		.key        (key),
		.value_in   (value_in),
		.busy       (busy),
		.cap        (cap_q),
		.out_free   (out_free),
		.res_vld    (res_vld),
		.res_status (res_status),
		.res_value  (res_value),
		.count      (count_w),
		.rd_addr    (rd_addr),
		.wr         (wr),
		.kv_addr    (kv_addr),
		.key_wdata  (key_wdata),
		.val_wdata  (val_wdata),
		.rank_addr  (rank_addr),
		.rank_wdata (rank_wdata),
		.key_rdata  (key_rdata),
		.val_rdata  (val_rdata),
		.rank_rdata (rank_rdata)
	);

	// entry memories
	lkv_store #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk        (clk),
		.rd_addr    (rd_addr),
		.wr         (wr),
		.kv_addr    (kv_addr),
		.key_wdata  (key_wdata),
		.val_wdata  (val_wdata),
		.rank_addr  (rank_addr),
		.rank_wdata (rank_wdata),
		.key_rdata  (key_rdata),
		.val_rdata  (val_rdata),
		.rank_rdata (rank_rdata)
	);

	assign req_stall = busy;

	// output register
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_vld) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			rsp_status_q <= res_status;
			rsp_value_q  <= res_value;
			rsp_occ_q    <= OCC_W'(count_w);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = rsp_status_q;
	assign value_out = rsp_value_q;
	assign occupancy = rsp_occ_q;

	// checks
	`LKV_ASSERT(a_busy_after_transfer, clk, arst_n, req_valid && !req_stall |=> req_stall)
	`LKV_NEVER(a_no_result_overwrite, clk, arst_n, res_vld && rsp_valid_q && rsp_stall)
	`LKV_ASSERT(a_count_moves_when_busy, clk, arst_n, !$stable(count_w) |-> $past(req_stall))

endmodule
